>>> sv/rtpf_pkg.sv
// ----------------------------------------------------------------------------
// rtpf_pkg
// shared types and constants of the resonant two-pole low-pass filter
// ----------------------------------------------------------------------------
`default_nettype none

package rtpf_pkg;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OMEGA,
      S_W2,
      S_M2W,
      S_PB,
      S_WX,
      S_DIV,
      S_WB
   } state_type;

   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 36;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   localparam int DIV_N_W = 64;
   localparam int DIV_D_W = 38;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   localparam int CSR_ADDR_W = 3;
   localparam logic REG_SAMPLE_RATE = 1'b0;

   localparam logic [17:0] RATE_RESET = 18'd48000;
   localparam logic [12:0] TWO_PI_NUM = 13'd6283;
   localparam logic [9:0] TWO_PI_DEN = 10'd1000;
   localparam logic [29:0] WT_CAP = 30'h3FFF_FFFF;

   localparam logic [23:0] SAMPLE_MAX = 24'h7F_FFFF;
   localparam logic [23:0] SAMPLE_MIN = 24'h80_0000;

endpackage

`default_nettype wire

>>> sv/resonant_two_pole_low_pass_filter.sv
// ----------------------------------------------------------------------------
// resonant_two_pole_low_pass_filter
// backward-euler two-pole resonant low-pass, cutoff and damping per request
// ----------------------------------------------------------------------------
// One request is worked at a time: a serial division for the time step,
// four serial multiplies (wt squared, damping term, feedback term, input
// term) and a serial division by d, each unit doing one bit per cycle,
// with registered start and done handoffs between the steps. A finished
// result sits in the output register while the next request is taken.
// sample_rate is written at byte address 0 of the register port.
`default_nettype none

module resonant_two_pole_low_pass_filter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [23:0]                  req_sample_in,
   input  wire logic        [15:0]                  req_cutoff_hz,
   input  wire logic        [15:0]                  req_damping,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed      [23:0]                  rsp_sample_out,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic        [rtpf_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic        [31:0]                  pwdata,
   output logic             [31:0]                  prdata,
   output logic                                     pready
);

   rtpf_pkg::state_type state_ff, state_in;

   logic                 go_ff, go_in;
   logic                 accept;
   logic                 wb_load;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [17:0]          rate_ff;
   logic signed [23:0]   x_ff;
   logic [15:0]          cut_ff;
   logic [15:0]          damp_ff;
   logic [29:0]          wt_ff;
   logic [35:0]          w2_ff;
   logic [34:0]          m2w_ff;
   logic signed [63:0]   acc_ff;
   logic [23:0]          qsat_ff;
   logic signed [23:0]   prev_ff;
   logic signed [23:0]   pprev_ff;
   logic [23:0]          out_ff;

   logic                                       mul_start, mul_done;
   logic signed [rtpf_pkg::MUL_A_W-1:0]        mul_a;
   logic [rtpf_pkg::MUL_B_W-1:0]               mul_b;
   logic signed [rtpf_pkg::MUL_P_W-1:0]        mul_p;
   logic                                       div_start, div_done;
   logic [rtpf_pkg::DIV_N_W-1:0]               div_n;
   logic [rtpf_pkg::DIV_D_W-1:0]               div_d;
   logic [rtpf_pkg::DIV_N_W-1:0]               div_q;

   logic [28:0]          cut_scaled;
   logic [27:0]          rate_scaled;
   logic [63:0]          acc_mag;
   logic [29:0]          wt_sat;
   logic [23:0]          q_sat;
   logic                 cfg_write;

   // register port
   assign cfg_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == rtpf_pkg::REG_SAMPLE_RATE) ? {14'd0, rate_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= rtpf_pkg::RATE_RESET;
      end else if (cfg_write && paddr[2] == rtpf_pkg::REG_SAMPLE_RATE) begin
         rate_ff <= pwdata[17:0];
      end
   end

   // sequencer
   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtpf_pkg::S_IDLE:  if (accept)   state_in = rtpf_pkg::S_OMEGA;
         rtpf_pkg::S_OMEGA: if (div_done) state_in = rtpf_pkg::S_W2;
         rtpf_pkg::S_W2:    if (mul_done) state_in = rtpf_pkg::S_M2W;
         rtpf_pkg::S_M2W:   if (mul_done) state_in = rtpf_pkg::S_PB;
         rtpf_pkg::S_PB:    if (mul_done) state_in = rtpf_pkg::S_WX;
         rtpf_pkg::S_WX:    if (mul_done) state_in = rtpf_pkg::S_DIV;
         rtpf_pkg::S_DIV:   if (div_done) state_in = rtpf_pkg::S_WB;
         rtpf_pkg::S_WB:    if (!rsp_valid_ff || !rsp_stall) state_in = rtpf_pkg::S_IDLE;
         default:           state_in = rtpf_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != rtpf_pkg::S_IDLE);
      wb_load   = (state_ff == rtpf_pkg::S_WB) && (!rsp_valid_ff || !rsp_stall);
      go_in     = (state_in != state_ff) && (state_in != rtpf_pkg::S_IDLE)
               && (state_in != rtpf_pkg::S_WB);
      mul_start = go_ff && (state_ff == rtpf_pkg::S_W2 || state_ff == rtpf_pkg::S_M2W
               || state_ff == rtpf_pkg::S_PB || state_ff == rtpf_pkg::S_WX);
      div_start = go_ff && (state_ff == rtpf_pkg::S_OMEGA || state_ff == rtpf_pkg::S_DIV);
      rsp_valid_in = wb_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtpf_pkg::S_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         pprev_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wb_load) begin
            pprev_ff <= prev_ff;
            prev_ff  <= qsat_ff;
         end
      end
   end

   // operand selection
   assign cut_scaled  = 29'(cut_ff) * 29'(rtpf_pkg::TWO_PI_NUM);
   assign rate_scaled = 28'(rate_ff) * 28'(rtpf_pkg::TWO_PI_DEN);
   assign acc_mag     = acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_n = '0;
      div_d = '0;
      unique case (state_ff)
         rtpf_pkg::S_OMEGA: begin
            div_n = {11'd0, cut_scaled, 24'd0};
            div_d = 38'(rate_scaled);
         end
         rtpf_pkg::S_W2: begin
            mul_a = {2'b00, wt_ff};
            mul_b = {6'd0, wt_ff};
         end
         rtpf_pkg::S_M2W: begin
            mul_a = {16'd0, damp_ff};
            mul_b = {6'd0, wt_ff};
         end
         rtpf_pkg::S_PB: begin
            mul_a = {{8{prev_ff[23]}}, prev_ff};
            mul_b = {1'b0, m2w_ff} + 36'h0_0200_0000;
         end
         rtpf_pkg::S_WX: begin
            mul_a = {{8{x_ff[23]}}, x_ff};
            mul_b = w2_ff;
         end
         rtpf_pkg::S_DIV: begin
            div_n = acc_mag;
            div_d = {2'b00, w2_ff} + {3'b000, m2w_ff} + 38'h00_0100_0000;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign wt_sat = (div_q[63:30] != '0) ? rtpf_pkg::WT_CAP : div_q[29:0];

   always_comb begin
      if (acc_ff[63]) begin
         q_sat = (div_q > 64'd8388608) ? rtpf_pkg::SAMPLE_MIN : 24'(~div_q[23:0] + 24'd1);
      end else begin
         q_sat = (div_q > 64'd8388607) ? rtpf_pkg::SAMPLE_MAX : div_q[23:0];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= req_sample_in;
         cut_ff  <= req_cutoff_hz;
         damp_ff <= req_damping;
      end
      if (div_done && state_ff == rtpf_pkg::S_OMEGA) begin
         wt_ff <= wt_sat;
      end
      if (div_done && state_ff == rtpf_pkg::S_DIV) begin
         qsat_ff <= q_sat;
      end
      if (mul_done && state_ff == rtpf_pkg::S_W2) begin
         w2_ff <= mul_p[59:24];
      end
      if (mul_done && state_ff == rtpf_pkg::S_M2W) begin
         m2w_ff <= mul_p[45:11];
      end
      if (mul_done && state_ff == rtpf_pkg::S_PB) begin
         acc_ff <= $signed(mul_p[63:0]) - $signed({{16{pprev_ff[23]}}, pprev_ff, 24'd0});
      end
      if (mul_done && state_ff == rtpf_pkg::S_WX) begin
         acc_ff <= acc_ff + $signed(mul_p[63:0]);
      end
      if (wb_load) begin
         out_ff <= qsat_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_ff;

   rtpf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   rtpf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   // checks
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == rtpf_pkg::S_W2 || state_ff == rtpf_pkg::S_M2W
                 || state_ff == rtpf_pkg::S_PB || state_ff == rtpf_pkg::S_WX))
      else $error("multiplier finished outside a multiply step");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == rtpf_pkg::S_OMEGA || state_ff == rtpf_pkg::S_DIV))
      else $error("divider finished outside a divide step");

   a_rsp_from_wb: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == rtpf_pkg::S_WB)
      else $error("result raised without writeback");

   a_wb_free_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rtpf_pkg::S_WB && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("writeback stalled with an empty output register");

endmodule

`default_nettype wire

>>> sv/rtpf_mul.sv
// ----------------------------------------------------------------------------
// rtpf_mul
// bit-serial shift-add multiplier, signed multiplicand times unsigned multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module rtpf_mul (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [rtpf_pkg::MUL_A_W-1:0]   mcand,
   input  wire logic        [rtpf_pkg::MUL_B_W-1:0]   mplier,
   output logic                                       done,
   output logic signed      [rtpf_pkg::MUL_P_W-1:0]   product
);

   logic                                   busy_ff, busy_in;
   logic                                   done_ff, done_in;
   logic [rtpf_pkg::MUL_CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [rtpf_pkg::MUL_A_W:0]      hi_ff, hi_in;
   logic [rtpf_pkg::MUL_B_W-1:0]           lo_ff, lo_in;
   logic signed [rtpf_pkg::MUL_A_W-1:0]    mc_ff, mc_in;
   logic signed [rtpf_pkg::MUL_A_W+1:0]    sum;

   always_comb begin
      sum = {hi_ff[rtpf_pkg::MUL_A_W], hi_ff}
          + (lo_ff[0] ? {{2{mc_ff[rtpf_pkg::MUL_A_W-1]}}, mc_ff}
                      : '0);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      mc_in   = mc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         hi_in   = '0;
         lo_in   = mplier;
         mc_in   = mcand;
      end else if (busy_ff) begin
         hi_in  = sum[rtpf_pkg::MUL_A_W+1:1];
         lo_in  = {sum[0], lo_ff[rtpf_pkg::MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rtpf_pkg::MUL_CNT_W'(rtpf_pkg::MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      mc_ff <= mc_in;
   end

   assign done    = done_ff;
   assign product = rtpf_pkg::MUL_P_W'({hi_ff, lo_ff});

endmodule

`default_nettype wire

>>> sv/rtpf_div.sv
// ----------------------------------------------------------------------------
// rtpf_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rtpf_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [rtpf_pkg::DIV_N_W-1:0]      dividend,
   input  wire logic [rtpf_pkg::DIV_D_W-1:0]      divisor,
   output logic                                   done,
   output logic [rtpf_pkg::DIV_N_W-1:0]           quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [rtpf_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [rtpf_pkg::DIV_D_W-1:0]       rem_ff, rem_in;
   logic [rtpf_pkg::DIV_N_W-1:0]       q_ff, q_in;
   logic [rtpf_pkg::DIV_D_W-1:0]       dv_ff, dv_in;
   logic [rtpf_pkg::DIV_D_W:0]         trial;
   logic [rtpf_pkg::DIV_D_W:0]         diff;
   logic                               fits;

   always_comb begin
      trial = {rem_ff, q_ff[rtpf_pkg::DIV_N_W-1]};
      diff  = trial - {1'b0, dv_ff};
      fits  = trial >= {1'b0, dv_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      dv_in   = dv_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         q_in    = dividend;
         dv_in   = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[rtpf_pkg::DIV_D_W-1:0] : trial[rtpf_pkg::DIV_D_W-1:0];
         q_in   = {q_ff[rtpf_pkg::DIV_N_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rtpf_pkg::DIV_CNT_W'(rtpf_pkg::DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dv_ff  <= dv_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// regression of the resonant two-pole low-pass filter: directed corners,
// several sample rates, a held output stall and random modulated requests,
// checked against a bit-exact fixed-point model, random idling both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [23:0] req_sample_in = '0;
   logic [15:0] req_cutoff_hz = '0;
   logic [15:0] req_damping = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [23:0] rsp_sample_out;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [rtpf_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   resonant_two_pole_low_pass_filter dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [17:0] rate_model;
   logic signed [31:0] y1_model, y2_model;
   logic signed [23:0] expected_out[$];
   int errors = 0;
   int checked = 0;
   bit quiet = 0;
   bit hold_off = 0;

   function automatic logic signed [23:0] filter_step(logic signed [23:0] x,
         logic [15:0] fc, logic [15:0] damp);
      logic [63:0] wt, w2, m2w, b, d;
      logic signed [63:0] numer, q;
      begin
         if (rate_model == 0) wt = {34'd0, rtpf_pkg::WT_CAP};
         else begin
            wt = ({48'd0, fc} * 64'd6283 * (64'd1 << 24)) / (64'd1000 * rate_model);
            if (wt > {34'd0, rtpf_pkg::WT_CAP}) wt = {34'd0, rtpf_pkg::WT_CAP};
         end
         w2 = (wt * wt) >> 24;
         m2w = (64'd2 * damp * wt) >> 12;
         b = m2w + (64'd2 << 24);
         d = w2 + m2w + (64'd1 << 24);
         numer = 64'(y1_model) * $signed(b) - 64'(y2_model) * 64'sd16777216
               + $signed(w2) * 64'(x);
         q = numer / $signed(d);
         if (q > 64'sd8388607) q = 64'sd8388607;
         if (q < -64'sd8388608) q = -64'sd8388608;
         y2_model = y1_model;
         y1_model = 32'(q);
         return q[23:0];
      end
   endfunction

   task automatic send_sample(logic signed [23:0] x, logic [15:0] fc, logic [15:0] damp);
      while (!quiet && $urandom_range(99) < 14) @(posedge clock);
      expected_out.push_back(filter_step(x, fc, damp));
      req_valid <= 1'b1;
      req_sample_in <= x;
      req_cutoff_hz <= fc;
      req_damping <= damp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_rate(logic [31:0] value);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      rate_model = value[17:0];
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_out.size() == 0) begin
            $display("%0t unexpected result: expected none actual %0d", $time,
               rsp_sample_out);
            errors++;
         end else begin
            if (rsp_sample_out !== expected_out[0]) begin
               $display("%0t sample_out mismatch: expected %0d actual %0d", $time,
                  expected_out[0], rsp_sample_out);
               errors++;
            end
            void'(expected_out.pop_front());
            checked++;
         end
      end
      if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= !quiet && ($urandom_range(99) < 14);
   end

   task automatic test_directed;
      send_sample(24'sh7FFFFF, 16'd1000, 16'd4096);
      send_sample(24'sh7FFFFF, 16'd65535, 16'd0);
      send_sample(-24'sh800000, 16'd65535, 16'd65535);
      send_sample(-24'sh800000, 16'd20000, 16'd100);
      send_sample(24'sh7FFFFF, 16'd0, 16'd0);
      send_sample(24'sh123456, 16'd0, 16'd65535);
      send_sample(24'sh000000, 16'd1, 16'd1);
      send_sample(-24'sh000001, 16'd500, 16'd200);
      send_sample(24'sh7FFFFF, 16'd30000, 16'd0);
      send_sample(-24'sh800000, 16'd30000, 16'd0);
      send_sample(24'sh555555, 16'd12345, 16'd65535);
      send_sample(-24'sh2AAAAA, 16'd43690, 16'd21845);
      drain();
   endtask

   task automatic test_rates;
      logic [31:0] rates[7];
      rates = '{32'd8000, 32'd192000, 32'd0, 32'd100, 32'h3FFFF, 32'hFFFC_0000 | 32'd44100,
                32'd96000};
      foreach (rates[i]) begin
         write_rate(rates[i]);
         send_sample(24'sh7FFFFF, 16'd65535, 16'd65535);
         send_sample(-24'sh800000, 16'd0, 16'd4096);
         repeat (8) send_sample(24'($urandom), 16'($urandom), 16'($urandom));
         drain();
      end
      write_rate(32'd48000);
   endtask

   task automatic test_random;
      for (int i = 0; i < 820; i++) begin
         if (i == 300) quiet = 1;
         if (i == 400) quiet = 0;
         if (i % 200 == 199) begin
            drain();
            write_rate($urandom_range(1) ? $urandom_range(192000, 8000) : $urandom);
         end
         case ($urandom_range(3))
            0: send_sample(24'($urandom), 16'($urandom), 16'($urandom));
            1: send_sample(24'($urandom), 16'($urandom_range(2000)),
                  16'($urandom_range(8192)));
            2: send_sample($urandom_range(1) ? 24'sh7FFFFF : -24'sh800000,
                  16'($urandom), 16'($urandom_range(65535, 60000)));
            default: send_sample(24'($urandom), 16'($urandom_range(20000, 200)),
                  16'($urandom_range(3000)));
         endcase
      end
      drain();
   endtask

   task automatic test_backpressure;
      fork
         begin
            hold_off = 1;
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         repeat (6) send_sample(24'($urandom), 16'($urandom), 16'($urandom));
      join
      drain();
   endtask

   initial begin
      rate_model = rtpf_pkg::RATE_RESET;
      y1_model = 0;
      y2_model = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_rates();
      test_backpressure();
      test_random();
      $display("covered directed corners, %0d sample rates, stalls and random modulation", 8);
      $display("%0d filtered samples checked", checked);
      if (errors == 0 && expected_out.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
